[rtl/cect_pkg.sv]
// Shared types, widths, rounding helpers and coefficient tables for the
// circle versus ellipse contact test. No dependencies.
package cect_pkg;

  localparam int ITERATIONS = 8;
  localparam int ROM_ROUNDS = 16;
  localparam int COEF_W     = 30;
  localparam int CW         = 40;
  localparam int PW         = 2 * CW + 2;
  localparam int QW         = 2 * PW;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [PW-1:0] p2_t;
  typedef logic signed [QW-1:0] p4_t;

  typedef struct packed {
    logic        [30:0] radius;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [30:0] semi_axis_x;
    logic        [30:0] semi_axis_y;
  } in_t;

  typedef struct packed {
    logic touches_boundary;
    logic wholly_inside;
  } out_t;

  typedef struct packed {
    crd_t r;
    crd_t x;
    crd_t y;
    p2_t  rr;
    crd_t c0x;
    crd_t c0y;
    crd_t c2x;
    crd_t c2y;
    logic done;
    logic touch;
    logic enclosed;
  } st_t;

  localparam logic [COEF_W-1:0] INNER_ROM [ROM_ROUNDS] = '{
    30'd759250125, 30'd581104888, 30'd547388835, 30'd539468601,
    30'd537518376, 30'd537032656, 30'd536911340, 30'd536881019,
    30'd536873439, 30'd536871544, 30'd536871070, 30'd536870951,
    30'd536870922, 30'd536870914, 30'd536870913, 30'd536870912
  };

  localparam logic [COEF_W-1:0] OUTER_ROM [ROM_ROUNDS] = '{
    30'd628983398, 30'd558112816, 30'd542078859, 30'd538166622,
    30'd537194449, 30'd536951772, 30'd536891125, 30'd536875965,
    30'd536872175, 30'd536871228, 30'd536870991, 30'd536870932,
    30'd536870917, 30'd536870913, 30'd536870912, 30'd536870912
  };

  function automatic p2_t mul2(crd_t a, crd_t b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return p2_t'(p);
  endfunction

  // s is nonnegative; round half up
  function automatic crd_t scl(crd_t s, logic [COEF_W-1:0] coef);
    logic [CW-1+COEF_W-1:0] p;
    p = s[CW-2:0] * coef + {1'b1, {(COEF_W-1){1'b0}}};
    return crd_t'({1'b0, p[CW-1+COEF_W-1:COEF_W]});
  endfunction

endpackage

[rtl/cect_mul.sv]
// Two-stage signed multiplier built from 32x32 partial products.
// Depends on cect_pkg.
module cect_mul #(
  parameter int W = cect_pkg::PW
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int N  = (W + 31) / 32;
  localparam int MW = N * 32;

  logic [W-1:0]       aa, bb;
  logic [MW-1:0]      ma, mb;
  logic [63:0]        pp_q [N][N];
  logic               neg_q;
  logic [2*MW-1:0]    acc;
  logic signed [2*W-1:0] p_d, p_q;

  always_comb begin
    aa = a_i[W-1] ? W'(-a_i) : W'(a_i);
    bb = b_i[W-1] ? W'(-b_i) : W'(b_i);
    ma = MW'(aa);
    mb = MW'(bb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= a_i[W-1] ^ b_i[W-1];
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp_q[i][j] <= ma[32*i +: 32] * mb[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        acc = acc + ((2*MW)'(pp_q[i][j]) << (32 * (i + j)));
      end
    end
    p_d = neg_q ? (2*W)'(-acc) : (2*W)'(acc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/cect_front.sv]
// Front pipeline: quadrant fold, quick accept and reject tests, inside test.
// Depends on cect_pkg and cect_mul.
module cect_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            v_i,
  input  cect_pkg::in_t   d_i,
  output logic            v_o,
  output cect_pkg::st_t   st_o
);

  typedef struct packed {
    cect_pkg::crd_t r, x, y, w, h;
  } f1_t;

  typedef struct packed {
    cect_pkg::crd_t r, x, y, w, h;
    cect_pkg::p2_t  rr, xx, yy, hy2, wx2, ww, hh, wh, xh, yw;
  } f2_t;

  typedef struct packed {
    cect_pkg::crd_t r, x, y, w, h;
    cect_pkg::p2_t  rr, a1, a2, dd, s, dst, xx, yy, ww, hh;
  } f3_t;

  typedef struct packed {
    cect_pkg::crd_t r, x, y, w, h;
    cect_pkg::p2_t  rr;
    logic           qa, dpos, reach;
  } f4_t;

  logic [5:0]      v_q;
  f1_t             f1_d, f1_q;
  f2_t             f2_d, f2_q;
  f3_t             f3_d, f3_q;
  f4_t             f4_d, f4_q, f5_q;
  cect_pkg::st_t   st_d, st_q;
  cect_pkg::crd_t  cx, cy;
  cect_pkg::p4_t   m_rs, m_dd, m_xh, m_yw, m_wh;

  always_comb begin
    cx     = cect_pkg::crd_t'(d_i.center_x);
    cy     = cect_pkg::crd_t'(d_i.center_y);
    f1_d.r = cect_pkg::crd_t'({1'b0, d_i.radius});
    f1_d.x = cx[cect_pkg::CW-1] ? -cx : cx;
    f1_d.y = cy[cect_pkg::CW-1] ? -cy : cy;
    f1_d.w = cect_pkg::crd_t'({1'b0, d_i.semi_axis_x});
    f1_d.h = cect_pkg::crd_t'({1'b0, d_i.semi_axis_y});
  end

  always_comb begin
    f2_d.r   = f1_q.r;
    f2_d.x   = f1_q.x;
    f2_d.y   = f1_q.y;
    f2_d.w   = f1_q.w;
    f2_d.h   = f1_q.h;
    f2_d.rr  = cect_pkg::mul2(f1_q.r, f1_q.r);
    f2_d.xx  = cect_pkg::mul2(f1_q.x, f1_q.x);
    f2_d.yy  = cect_pkg::mul2(f1_q.y, f1_q.y);
    f2_d.hy2 = cect_pkg::mul2(f1_q.h - f1_q.y, f1_q.h - f1_q.y);
    f2_d.wx2 = cect_pkg::mul2(f1_q.w - f1_q.x, f1_q.w - f1_q.x);
    f2_d.ww  = cect_pkg::mul2(f1_q.w, f1_q.w);
    f2_d.hh  = cect_pkg::mul2(f1_q.h, f1_q.h);
    f2_d.wh  = cect_pkg::mul2(f1_q.w, f1_q.h);
    f2_d.xh  = cect_pkg::mul2(f1_q.x, f1_q.h);
    f2_d.yw  = cect_pkg::mul2(f1_q.y, f1_q.w);
  end

  always_comb begin
    f3_d.r    = f2_q.r;
    f3_d.x    = f2_q.x;
    f3_d.y    = f2_q.y;
    f3_d.w    = f2_q.w;
    f3_d.h    = f2_q.h;
    f3_d.rr   = f2_q.rr;
    f3_d.a1   = f2_q.xx + f2_q.hy2;
    f3_d.a2   = f2_q.wx2 + f2_q.yy;
    f3_d.dd   = f2_q.wh - f2_q.xh - f2_q.yw;
    f3_d.s    = f2_q.hh + f2_q.ww;
    f3_d.dst  = f2_q.wx2 + f2_q.hy2;
    f3_d.xx   = f2_q.xx;
    f3_d.yy   = f2_q.yy;
    f3_d.ww   = f2_q.ww;
    f3_d.hh   = f2_q.hh;
  end

  cect_mul u_m_rs (.clk_i, .en_i, .a_i(f3_q.rr), .b_i(f3_q.s),  .p_o(m_rs));
  cect_mul u_m_dd (.clk_i, .en_i, .a_i(f3_q.dd), .b_i(f3_q.dd), .p_o(m_dd));
  cect_mul u_m_xh (.clk_i, .en_i, .a_i(f3_q.xx), .b_i(f3_q.hh), .p_o(m_xh));
  cect_mul u_m_yw (.clk_i, .en_i, .a_i(f3_q.yy), .b_i(f3_q.ww), .p_o(m_yw));
  cect_mul u_m_wh (.clk_i, .en_i, .a_i(f3_q.ww), .b_i(f3_q.hh), .p_o(m_wh));

  always_comb begin
    f4_d.r     = f3_q.r;
    f4_d.x     = f3_q.x;
    f4_d.y     = f3_q.y;
    f4_d.w     = f3_q.w;
    f4_d.h     = f3_q.h;
    f4_d.rr    = f3_q.rr;
    f4_d.qa    = (f3_q.a1 <= f3_q.rr) || (f3_q.a2 <= f3_q.rr);
    f4_d.dpos  = f3_q.dd >= 0;
    f4_d.reach = (f3_q.dst <= f3_q.rr) ||
                 ((f3_q.x <= f3_q.w) && (f3_q.y - f3_q.r <= f3_q.h)) ||
                 ((f3_q.y <= f3_q.h) && (f3_q.x - f3_q.r <= f3_q.w));
  end

  always_comb begin
    st_d.r        = f5_q.r;
    st_d.x        = f5_q.x;
    st_d.y        = f5_q.y;
    st_d.rr       = f5_q.rr;
    st_d.c0x      = f5_q.w;
    st_d.c0y      = '0;
    st_d.c2x      = '0;
    st_d.c2y      = f5_q.h;
    st_d.touch    = f5_q.qa;
    st_d.done     = f5_q.qa || (f5_q.dpos && (m_rs <= m_dd)) || !f5_q.reach;
    st_d.enclosed = (m_xh + m_yw) < m_wh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
      f3_q <= f3_d;
      f4_q <= f4_d;
      f5_q <= f4_q;
      st_q <= st_d;
    end
  end

  assign v_o  = v_q[5];
  assign st_o = st_q;

endmodule

[rtl/cect_round.sv]
// One polygon refinement round, seven register stages.
// Depends on cect_pkg and cect_mul.
module cect_round #(
  parameter int ROUND = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            v_i,
  input  cect_pkg::st_t   st_i,
  output logic            v_o,
  output cect_pkg::st_t   st_o
);

  localparam logic [cect_pkg::COEF_W-1:0] INNER = cect_pkg::INNER_ROM[ROUND];
  localparam logic [cect_pkg::COEF_W-1:0] OUTER = cect_pkg::OUTER_ROM[ROUND];

  typedef struct packed {
    cect_pkg::st_t  st;
    cect_pkg::crd_t c1x, c1y;
  } r1_t;

  typedef struct packed {
    cect_pkg::st_t  st;
    cect_pkg::crd_t c1x, c1y, tx, ty, t2x, t2y, t0x, t0y, c3x, c3y;
  } r2_t;

  typedef struct packed {
    cect_pkg::st_t  st;
    cect_pkg::crd_t c1x, c1y, tx, ty, t3x, t3y;
    cect_pkg::crd_t f3x, f3y, g3x, g3y, f4x, f4y, g4x, g4y;
    cect_pkg::p2_t  tt, k2, k0, d2, n2, d0, n0;
  } r3_t;

  typedef struct packed {
    cect_pkg::st_t  st;
    cect_pkg::crd_t c1x, c1y;
    cect_pkg::p2_t  tt, k2, k0, d2, n2, d0, n0, k3, n3, d3, q3, q4, e3, e4;
  } r4_t;

  typedef struct packed {
    cect_pkg::st_t  st;
    cect_pkg::crd_t c1x, c1y;
    logic           acc, prj, in3, in4, k3np, d3pos, a3, e3nn, e4nn;
  } r5_t;

  logic [6:0]      v_q;
  r1_t             r1_d, r1_q;
  r2_t             r2_d, r2_q;
  r3_t             r3_d, r3_q;
  r4_t             r4_d, r4_q;
  r5_t             r5_d, r5_q, r6_q;
  cect_pkg::st_t   st_d, st_q;
  cect_pkg::p4_t   m_rn2, m_k2, m_rn0, m_k0, m_rn3, m_k3;

  always_comb begin
    r1_d.st  = st_i;
    r1_d.c1x = cect_pkg::scl(st_i.c0x + st_i.c2x, INNER);
    r1_d.c1y = cect_pkg::scl(st_i.c0y + st_i.c2y, INNER);
  end

  always_comb begin
    r2_d.st  = r1_q.st;
    r2_d.c1x = r1_q.c1x;
    r2_d.c1y = r1_q.c1y;
    r2_d.tx  = r1_q.st.x - r1_q.c1x;
    r2_d.ty  = r1_q.st.y - r1_q.c1y;
    r2_d.t2x = r1_q.st.c2x - r1_q.c1x;
    r2_d.t2y = r1_q.st.c2y - r1_q.c1y;
    r2_d.t0x = r1_q.st.c0x - r1_q.c1x;
    r2_d.t0y = r1_q.st.c0y - r1_q.c1y;
    r2_d.c3x = cect_pkg::scl(r1_q.st.c0x + r1_q.c1x, OUTER);
    r2_d.c3y = cect_pkg::scl(r1_q.st.c0y + r1_q.c1y, OUTER);
  end

  always_comb begin
    cect_pkg::crd_t c4x, c4y;
    c4x      = (r2_q.c1x <<< 1) - r2_q.c3x;
    c4y      = (r2_q.c1y <<< 1) - r2_q.c3y;
    r3_d.st  = r2_q.st;
    r3_d.c1x = r2_q.c1x;
    r3_d.c1y = r2_q.c1y;
    r3_d.tx  = r2_q.tx;
    r3_d.ty  = r2_q.ty;
    r3_d.t3x = r2_q.c3x - r2_q.c1x;
    r3_d.t3y = r2_q.c3y - r2_q.c1y;
    r3_d.f3x = r2_q.st.x - r2_q.c3x;
    r3_d.f3y = r2_q.st.y - r2_q.c3y;
    r3_d.g3x = r2_q.st.c0x - r2_q.c3x;
    r3_d.g3y = r2_q.st.c0y - r2_q.c3y;
    r3_d.f4x = r2_q.st.x - c4x;
    r3_d.f4y = r2_q.st.y - c4y;
    r3_d.g4x = r2_q.st.c2x - c4x;
    r3_d.g4y = r2_q.st.c2y - c4y;
    r3_d.tt  = cect_pkg::mul2(r2_q.tx, r2_q.tx) + cect_pkg::mul2(r2_q.ty, r2_q.ty);
    r3_d.k2  = cect_pkg::mul2(r2_q.ty, r2_q.t2x) - cect_pkg::mul2(r2_q.tx, r2_q.t2y);
    r3_d.k0  = cect_pkg::mul2(r2_q.ty, r2_q.t0x) - cect_pkg::mul2(r2_q.tx, r2_q.t0y);
    r3_d.d2  = cect_pkg::mul2(r2_q.tx, r2_q.t2x) + cect_pkg::mul2(r2_q.ty, r2_q.t2y);
    r3_d.n2  = cect_pkg::mul2(r2_q.t2x, r2_q.t2x) + cect_pkg::mul2(r2_q.t2y, r2_q.t2y);
    r3_d.d0  = cect_pkg::mul2(r2_q.tx, r2_q.t0x) + cect_pkg::mul2(r2_q.ty, r2_q.t0y);
    r3_d.n0  = cect_pkg::mul2(r2_q.t0x, r2_q.t0x) + cect_pkg::mul2(r2_q.t0y, r2_q.t0y);
  end

  always_comb begin
    r4_d.st  = r3_q.st;
    r4_d.c1x = r3_q.c1x;
    r4_d.c1y = r3_q.c1y;
    r4_d.tt  = r3_q.tt;
    r4_d.k2  = r3_q.k2;
    r4_d.k0  = r3_q.k0;
    r4_d.d2  = r3_q.d2;
    r4_d.n2  = r3_q.n2;
    r4_d.d0  = r3_q.d0;
    r4_d.n0  = r3_q.n0;
    r4_d.k3  = cect_pkg::mul2(r3_q.ty, r3_q.t3x) - cect_pkg::mul2(r3_q.tx, r3_q.t3y);
    r4_d.n3  = cect_pkg::mul2(r3_q.t3x, r3_q.t3x) + cect_pkg::mul2(r3_q.t3y, r3_q.t3y);
    r4_d.d3  = cect_pkg::mul2(r3_q.tx, r3_q.t3x) + cect_pkg::mul2(r3_q.ty, r3_q.t3y);
    r4_d.q3  = cect_pkg::mul2(r3_q.f3x, r3_q.f3x) + cect_pkg::mul2(r3_q.f3y, r3_q.f3y);
    r4_d.q4  = cect_pkg::mul2(r3_q.f4x, r3_q.f4x) + cect_pkg::mul2(r3_q.f4y, r3_q.f4y);
    r4_d.e3  = cect_pkg::mul2(r3_q.f3x, r3_q.g3x) + cect_pkg::mul2(r3_q.f3y, r3_q.g3y);
    r4_d.e4  = cect_pkg::mul2(r3_q.f4x, r3_q.g4x) + cect_pkg::mul2(r3_q.f4y, r3_q.g4y);
  end

  cect_mul u_m_rn2 (.clk_i, .en_i, .a_i(r4_q.st.rr), .b_i(r4_q.n2), .p_o(m_rn2));
  cect_mul u_m_k2  (.clk_i, .en_i, .a_i(r4_q.k2),    .b_i(r4_q.k2), .p_o(m_k2));
  cect_mul u_m_rn0 (.clk_i, .en_i, .a_i(r4_q.st.rr), .b_i(r4_q.n0), .p_o(m_rn0));
  cect_mul u_m_k0  (.clk_i, .en_i, .a_i(r4_q.k0),    .b_i(r4_q.k0), .p_o(m_k0));
  cect_mul u_m_rn3 (.clk_i, .en_i, .a_i(r4_q.st.rr), .b_i(r4_q.n3), .p_o(m_rn3));
  cect_mul u_m_k3  (.clk_i, .en_i, .a_i(r4_q.k3),    .b_i(r4_q.k3), .p_o(m_k3));

  always_comb begin
    r5_d.st    = r4_q.st;
    r5_d.c1x   = r4_q.c1x;
    r5_d.c1y   = r4_q.c1y;
    r5_d.acc   = r4_q.tt <= r4_q.st.rr;
    r5_d.prj   = (r4_q.d2 <= r4_q.n2) && (r4_q.d0 <= r4_q.n0) &&
                 (r4_q.k2 >= 0) && (r4_q.k0 <= 0);
    r5_d.in3   = r4_q.q3 < r4_q.st.rr;
    r5_d.in4   = r4_q.q4 < r4_q.st.rr;
    r5_d.k3np  = r4_q.k3 <= 0;
    r5_d.d3pos = r4_q.d3 > 0;
    r5_d.a3    = ((r4_q.d3 < 0) ? -r4_q.d3 : r4_q.d3) <= r4_q.n3;
    r5_d.e3nn  = r4_q.e3 >= 0;
    r5_d.e4nn  = r4_q.e4 >= 0;
  end

  always_comb begin
    st_d = r6_q.st;
    if (!r6_q.st.done) begin
      priority if (r6_q.acc) begin
        st_d.done  = 1'b1;
        st_d.touch = 1'b1;
      end else if (r6_q.prj && (m_rn2 < m_k2) && (m_rn0 < m_k0)) begin
        st_d.done = 1'b1;
      end else if (r6_q.in3) begin
        st_d.c2x = r6_q.c1x;
        st_d.c2y = r6_q.c1y;
      end else if (r6_q.in4) begin
        st_d.c0x = r6_q.c1x;
        st_d.c0y = r6_q.c1y;
      end else if (r6_q.k3np || (m_rn3 > m_k3)) begin
        if (r6_q.d3pos) begin
          if (r6_q.a3 || r6_q.e3nn) begin
            st_d.c2x = r6_q.c1x;
            st_d.c2y = r6_q.c1y;
          end else begin
            st_d.done = 1'b1;
          end
        end else begin
          if (r6_q.a3 || r6_q.e4nn) begin
            st_d.c0x = r6_q.c1x;
            st_d.c0y = r6_q.c1y;
          end else begin
            st_d.done = 1'b1;
          end
        end
      end else begin
        st_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      r4_q <= r4_d;
      r5_q <= r5_d;
      r6_q <= r5_q;
      st_q <= st_d;
    end
  end

  assign v_o  = v_q[6];
  assign st_o = st_q;

endmodule

[rtl/circle_ellipse_contact_test_core.sv]
// Circle versus axis-aligned ellipse contact test, top level.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output waits, set by the single enable shared by all stages.
// Reset clears all valid bits; payload registers are not reset.
// Depends on cect_pkg, cect_front, cect_round and cect_mul.
module circle_ellipse_contact_test_core #(
  parameter int ITERATIONS = cect_pkg::ITERATIONS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cect_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cect_pkg::out_t  out_data_o
);

  localparam int NR = (ITERATIONS < cect_pkg::ROM_ROUNDS) ? ITERATIONS
                                                          : cect_pkg::ROM_ROUNDS;

  logic            en;
  logic            v   [NR+1];
  cect_pkg::st_t   st  [NR+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cect_front u_front (
    .clk_i,
    .rst_ni,
    .en_i (en),
    .v_i  (in_valid_i),
    .d_i  (in_data_i),
    .v_o  (v[0]),
    .st_o (st[0])
  );

  for (genvar g = 0; g < NR; g++) begin : g_round
    cect_round #(.ROUND(g)) u_round (
      .clk_i,
      .rst_ni,
      .en_i (en),
      .v_i  (v[g]),
      .st_i (st[g]),
      .v_o  (v[g+1]),
      .st_o (st[g+1])
    );
  end

  assign out_valid_o                 = v[NR];
  assign out_data_o.touches_boundary = st[NR].touch;
  assign out_data_o.wholly_inside    = !st[NR].touch && st[NR].enclosed;

endmodule
